// File: hw/rtl/bsfcr_pkg.sv
// Package: shared types, constants and the CRC-8 update function of the frame receiver.
`timescale 1ns / 1ps

package bsfcr_pkg;

	localparam int MAX_FRAME = 256;
	localparam int CNT_W     = $clog2(MAX_FRAME + 1);

	localparam logic [7:0] ESC_XOR       = 8'h20;
	localparam logic [7:0] MAGIC_RESET   = 8'hFE;
	localparam logic [7:0] ESCAPE_RESET  = 8'hFD;
	localparam logic [7:0] POLY_RESET    = 8'h8C;

	typedef enum logic [1:0] {
		CFG_MAGIC  = 2'd0,
		CFG_ESCAPE = 2'd1,
		CFG_POLY   = 2'd2
	} cfg_index_t;

	typedef enum logic [1:0] {
		KIND_PAYLOAD  = 2'd0,
		KIND_GOOD     = 2'd1,
		KIND_CRC_ERR  = 2'd2,
		KIND_OVERFLOW = 2'd3
	} kind_t;

	// Reflected, LSB-first CRC-8 update over one byte.
	function automatic logic [7:0] crc8_update(input logic [7:0] crc, input logic [7:0] d,
			input logic [7:0] poly);
		logic [7:0] c;
		c = crc ^ d;
		for (int i = 0; i < 8; i++) begin
			if (c[0]) begin
				c = (c >> 1) ^ poly;
			end else begin
				c = c >> 1;
			end
		end
		return c;
	endfunction

endpackage

// File: hw/rtl/byte_stuffed_frame_crc8_receiver.sv
// Byte-stuffed frame receiver with CRC-8 check: sole module and top level.
//
// Takes one raw line byte per request and accepts a new byte in every cycle unless
// in_stall is high. A byte goes into the input register; the CRC and framing update
// between it and the result register is combinational, and the byte's result, if
// any, is registered in the result register, giving one byte per clock while the
// output does not stall. Payload bytes leave one byte late, so a frame's trailing CRC
// byte is never passed on; the delimiter byte produces one status result (good, CRC
// error or overflow, payload length saturated at 255) unless the frame was empty.
// Configuration registers must only be written while no byte is in flight.
`timescale 1ns / 1ps

module byte_stuffed_frame_crc8_receiver
	import bsfcr_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_we,
	input  logic [1:0] cfg_index,
	input  logic [7:0] cfg_data,
	input  logic       in_valid,
	output logic       in_stall,
	input  logic [7:0] rx_byte,
	output logic       out_valid,
	input  logic       out_stall,
	output logic [1:0] kind,
	output logic [7:0] data_byte,
	output logic [7:0] frame_length
);

	logic [7:0] magic_q, escape_q, poly_q;

	logic       valid_s1;
	logic [7:0] rx_byte_s1;

	logic [7:0]     crc_q;
	logic           esc_pending_q;
	logic [7:0]     held_byte_q;
	logic           held_valid_q;
	logic [CNT_W-1:0] byte_count_q;
	logic           overflowed_q;

	logic       out_valid_q;
	kind_t      kind_q;
	logic [7:0] data_q;
	logic [7:0] len_q;

	logic advance;
	logic take;

	logic [7:0]       crc_d;
	logic             esc_pending_d;
	logic [7:0]       held_byte_d;
	logic             held_valid_d;
	logic [CNT_W-1:0] byte_count_d;
	logic             overflowed_d;
	logic             emit;
	kind_t            emit_kind;
	logic [7:0]       emit_data;
	logic [7:0]       emit_len;
	logic [7:0]       unesc;
	logic [CNT_W-1:0] len_full;

	// The result register frees up when it is empty or its request is taken.
	assign advance  = !out_valid_q || !out_stall;
	assign in_stall = valid_s1 && !advance;
	assign take     = valid_s1 && advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			magic_q  <= MAGIC_RESET;
			escape_q <= ESCAPE_RESET;
			poly_q   <= POLY_RESET;
		end else if (cfg_we) begin
			case (cfg_index_t'(cfg_index))
				CFG_MAGIC:  magic_q  <= cfg_data;
				CFG_ESCAPE: escape_q <= cfg_data;
				CFG_POLY:   poly_q   <= cfg_data;
				default:    ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			rx_byte_s1 <= rx_byte;
		end
	end

	assign unesc    = esc_pending_q ? (rx_byte_s1 ^ ESC_XOR) : rx_byte_s1;
	assign len_full = byte_count_q - CNT_W'(1);

	always_comb begin
		crc_d         = crc_q;
		esc_pending_d = esc_pending_q;
		held_byte_d   = held_byte_q;
		held_valid_d  = held_valid_q;
		byte_count_d  = byte_count_q;
		overflowed_d  = overflowed_q;
		emit          = 1'b0;
		emit_kind     = KIND_PAYLOAD;
		emit_data     = 8'd0;
		emit_len      = 8'd0;
		if (rx_byte_s1 == magic_q) begin
			if (byte_count_q != '0) begin
				emit     = 1'b1;
				emit_len = (len_full > CNT_W'(255)) ? 8'd255 : len_full[7:0];
				if (overflowed_q) begin
					emit_kind = KIND_OVERFLOW;
				end else if (crc_q != 8'd0) begin
					emit_kind = KIND_CRC_ERR;
				end else begin
					emit_kind = KIND_GOOD;
				end
			end
			crc_d         = 8'd0;
			esc_pending_d = 1'b0;
			held_byte_d   = 8'd0;
			held_valid_d  = 1'b0;
			byte_count_d  = '0;
			overflowed_d  = 1'b0;
		end else if (rx_byte_s1 == escape_q) begin
			esc_pending_d = 1'b1;
		end else begin
			esc_pending_d = 1'b0;
			crc_d         = crc8_update(crc_q, unesc, poly_q);
			if (!overflowed_q) begin
				if (byte_count_q == CNT_W'(MAX_FRAME)) begin
					// Frame too long: drop the held byte and everything after it.
					overflowed_d = 1'b1;
					held_valid_d = 1'b0;
				end else begin
					emit         = held_valid_q;
					emit_data    = held_byte_q;
					held_byte_d  = unesc;
					held_valid_d = 1'b1;
					byte_count_d = byte_count_q + CNT_W'(1);
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			crc_q         <= 8'd0;
			esc_pending_q <= 1'b0;
			held_byte_q   <= 8'd0;
			held_valid_q  <= 1'b0;
			byte_count_q  <= '0;
			overflowed_q  <= 1'b0;
			out_valid_q   <= 1'b0;
		end else if (advance) begin
			out_valid_q <= take && emit;
			if (take) begin
				crc_q         <= crc_d;
				esc_pending_q <= esc_pending_d;
				held_byte_q   <= held_byte_d;
				held_valid_q  <= held_valid_d;
				byte_count_q  <= byte_count_d;
				overflowed_q  <= overflowed_d;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take && emit) begin
			kind_q <= emit_kind;
			data_q <= emit_data;
			len_q  <= emit_len;
		end
	end

	assign out_valid    = out_valid_q;
	assign kind         = kind_q;
	assign data_byte    = data_q;
	assign frame_length = len_q;

`ifndef SYNTHESIS
	a_stall_only_when_blocked: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> (valid_s1 && out_valid_q && out_stall))
		else $error("input stalled while the result register could advance");

	a_count_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		byte_count_q <= CNT_W'(MAX_FRAME))
		else $error("frame byte count beyond the frame limit");

	a_overflow_no_held: assert property (@(posedge clk) disable iff (!arst_n)
		overflowed_q |-> !held_valid_q)
		else $error("held byte still valid after overflow");

	a_status_fields: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && kind_q != KIND_PAYLOAD) |-> (data_q == 8'd0))
		else $error("status result carries a data byte");

	a_payload_fields: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && kind_q == KIND_PAYLOAD) |-> (len_q == 8'd0))
		else $error("payload result carries a frame length");
`endif

endmodule
